>>> sv/bwte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwte_pkg
// Shared constants and types of the block sorting transform encoder.
// ----------------------------------------------------------------------------
package bwte_pkg;

    localparam int BLOCK_SIZE_DEF = 32;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_SORT_INIT,
        ST_CMP_RD,
        ST_CMP_WAIT,
        ST_CMP_EVAL,
        ST_SHIFT,
        ST_PLACE,
        ST_IDX_CMP,
        ST_OUT_IDX,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_SEND
    } t_state;

endpackage

>>> sv/bwte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwte_in_if / bwte_out_if
// Valid/ready channels for the input bytes and the result beats.
// ----------------------------------------------------------------------------
interface bwte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;
    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface bwte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_index;
    logic       block_last;
    modport source (output valid, output out_byte, output is_index, output block_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_index, input block_last,
                    output ready);
endinterface

>>> sv/bwte_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwte_mem
// Single-write, dual-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module bwte_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

>>> sv/bwte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwte_ctrl
// Sequencer: fills the block buffer, insertion-sorts the rotations through
// the order memory, counts the primary index and streams out the result.
// ----------------------------------------------------------------------------
module bwte_ctrl
    import bwte_pkg::*;
#(
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
    localparam int AW = $clog2(BLOCK_SIZE),
    localparam int CW = $clog2(BLOCK_SIZE + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bwte_in_if.sink       s_in,
    bwte_out_if.source    m_out
);
    // block buffer memory
    logic          buf_we;
    logic [AW-1:0] buf_waddr, buf_ra, buf_rb;
    logic [7:0]    buf_wdata, buf_da, buf_db;
    // rotation order memory
    logic          ord_we;
    logic [AW-1:0] ord_waddr, ord_ra, ord_rb;
    logic [AW-1:0] ord_wdata, ord_da, ord_db;

    bwte_mem #(.DEPTH(BLOCK_SIZE), .WIDTH(8)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_raddr_a(buf_ra), .i_raddr_b(buf_rb), .o_rdata_a(buf_da), .o_rdata_b(buf_db));
    bwte_mem #(.DEPTH(BLOCK_SIZE), .WIDTH(AW)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr_a(ord_ra), .i_raddr_b(ord_rb), .o_rdata_a(ord_da), .o_rdata_b(ord_db));

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;   // bytes held, later block length
    logic [AW-1:0] r_i, n_i;         // element being inserted / output row
    logic [AW-1:0] r_j, n_j;         // insertion slot
    logic [AW-1:0] r_pa, n_pa;       // left rotation start
    logic [AW-1:0] r_pb, n_pb;       // right rotation start
    logic [AW-1:0] r_k, n_k;         // compare offset
    logic [AW-1:0] r_cnt, n_cnt;     // primary index count
    logic [AW-1:0] r_jm1, n_jm1;     // order entry at j-1
    logic          r_ov, n_ov;
    logic [7:0]    r_ob, n_ob;
    logic          r_oi, n_oi;
    logic          r_ol, n_ol;

    logic [AW-1:0] nm1;
    logic          cmp_last;

    // last index of the block
    assign nm1 = AW'(r_fill - CW'(1));
    assign cmp_last = (r_k == nm1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v,
                                               input logic [AW-1:0] last);
        wrap_inc = (v == last) ? '0 : AW'(v + AW'(1));
    endfunction

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_jm1 <= n_jm1;
        r_ob  <= n_ob;
        r_oi  <= n_oi;
        r_ol  <= n_ol;
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_fill = r_fill;
        n_i = r_i; n_j = r_j; n_pa = r_pa; n_pb = r_pb; n_k = r_k;
        n_cnt = r_cnt; n_jm1 = r_jm1;
        n_ov = r_ov; n_ob = r_ob; n_oi = r_oi; n_ol = r_ol;
        buf_we = 1'b0; buf_waddr = r_fill[AW-1:0]; buf_wdata = s_in.in_byte;
        buf_ra = r_pa; buf_rb = r_pb;
        ord_we = 1'b0; ord_waddr = r_j; ord_wdata = r_i;
        ord_ra = AW'(r_j - AW'(1)); ord_rb = r_i;
        s_in.ready = 1'b0;
        if (m_out.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_FILL: begin
                s_in.ready = 1'b1;
                if (s_in.valid) begin
                    buf_we = 1'b1;
                    n_fill = CW'(r_fill + CW'(1));
                    if (s_in.stream_end || (n_fill == CW'(BLOCK_SIZE))) begin
                        n_state = ST_SORT_INIT;
                    end
                end
            end
            ST_SORT_INIT: begin
                // row 0 always starts sorted
                ord_we = 1'b1; ord_waddr = '0; ord_wdata = '0;
                n_i = AW'(1); n_j = AW'(1); n_cnt = '0;
                n_state = (r_fill == CW'(1)) ? ST_OUT_IDX : ST_CMP_RD;
            end
            ST_CMP_RD: begin
                // fetch order[j-1]
                if (r_j == '0) begin
                    n_state = ST_PLACE;
                end else begin
                    n_state = ST_CMP_WAIT;
                end
            end
            ST_CMP_WAIT: begin
                n_jm1 = ord_da;
                n_pa = ord_da; n_pb = r_i; n_k = '0;
                n_state = ST_CMP_EVAL;
                buf_ra = ord_da; buf_rb = r_i;
            end
            ST_CMP_EVAL: begin
                // buffer data for offset k is valid now
                buf_ra = wrap_inc(r_pa, nm1); buf_rb = wrap_inc(r_pb, nm1);
                n_pa = buf_ra; n_pb = buf_rb; n_k = AW'(r_k + AW'(1));
                if (buf_da > buf_db) begin
                    n_state = ST_SHIFT;
                end else if (buf_da < buf_db || cmp_last) begin
                    n_state = ST_PLACE;
                end
            end
            ST_SHIFT: begin
                ord_we = 1'b1; ord_waddr = r_j; ord_wdata = r_jm1;
                n_j = AW'(r_j - AW'(1));
                n_state = ST_CMP_RD;
            end
            ST_PLACE: begin
                ord_we = 1'b1;
                if (r_i == nm1) begin
                    n_i = AW'(1); n_pa = AW'(1); n_pb = '0; n_k = '0;
                    n_state = ST_IDX_CMP;
                    buf_ra = AW'(1); buf_rb = '0;
                end else begin
                    n_i = AW'(r_i + AW'(1)); n_j = AW'(r_i + AW'(1));
                    n_state = ST_CMP_RD;
                end
            end
            ST_IDX_CMP: begin
                // count rotations below rotation 0; one byte a cycle
                buf_ra = wrap_inc(r_pa, nm1); buf_rb = wrap_inc(r_pb, nm1);
                n_pa = buf_ra; n_pb = buf_rb; n_k = AW'(r_k + AW'(1));
                if (buf_da != buf_db || cmp_last) begin
                    if (buf_da < buf_db) begin
                        n_cnt = AW'(r_cnt + AW'(1));
                    end
                    if (r_i == nm1) begin
                        n_state = ST_OUT_IDX;
                    end else begin
                        // start the next rotation; its first bytes arrive next cycle
                        n_i = AW'(r_i + AW'(1));
                        n_pa = AW'(r_i + AW'(1)); n_pb = '0; n_k = '0;
                        buf_ra = AW'(r_i + AW'(1)); buf_rb = '0;
                    end
                end
            end
            ST_OUT_IDX: begin
                if (!r_ov || m_out.ready) begin
                    n_ov = 1'b1; n_ob = 8'(r_cnt); n_oi = 1'b1; n_ol = 1'b0;
                    n_i = '0;
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                ord_rb = r_i;
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                // hold the address so the byte is re-read while the output stalls
                buf_ra = (ord_db == '0) ? nm1 : AW'(ord_db - AW'(1));
                n_pa = buf_ra;
                n_state = ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
                if (!r_ov || m_out.ready) begin
                    n_ov = 1'b1; n_ob = buf_da; n_oi = 1'b0; n_ol = (r_i == nm1);
                    if (r_i == nm1) begin
                        n_fill = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_i = AW'(r_i + AW'(1));
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    assign m_out.valid      = r_ov;
    assign m_out.out_byte   = r_ob;
    assign m_out.is_index   = r_oi;
    assign m_out.block_last = r_ol;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BLOCK_SIZE)) else $error("fill count beyond block size");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FILL) |-> !s_in.ready) else $error("input taken while busy");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> (r_ov && $stable(r_ob)))
        else $error("result beat lost under stall");
    a_index_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oi) |-> !r_ol)
        else $error("index beat marked as block end");
`endif
endmodule

>>> sv/bwt_block_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_block_encoder
// Block sorting transform encoder over blocks of up to BLOCK_SIZE bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one byte per beat with a stream-end flag. A block closes
//   after BLOCK_SIZE bytes or on a beat with stream_end set.
//   Output channel: per block of n bytes, n+1 beats: first the primary
//   index (is_index set), then the last column in sorted order, with
//   block_last on the final beat.
//   Filling accepts one byte per cycle while the input is valid. The
//   insertion sort runs in the sequencer against the order memory: each
//   rotation compare reads order[j-1], waits for it, then compares one
//   byte per cycle; each shift and each placement is a state of its own.
//   Counting the primary index compares one byte per cycle; the index beat
//   and then each last-column beat (read, wait, send) follow.
//   Input is not accepted while a block is sorted or sent.
//   Reset clears the sequencer and the fill count; memories need no clear.
//   A stalled receiver holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module bwt_block_encoder
    import bwte_pkg::*;
#(
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bwte_in_if.sink    s_in,
    bwte_out_if.source m_out
);
    bwte_ctrl #(.BLOCK_SIZE(BLOCK_SIZE)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_out(m_out));
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block sorting transform encoder. Byte blocks
// of many lengths and contents go in, with random gaps on both channels.
// A local rotation-sort predictor builds the index and last-column beats
// that each closed block must produce, and the monitor checks every beat.
// ----------------------------------------------------------------------------
module tb_top
    import bwte_pkg::*;
();

    localparam int NBLK      = BLOCK_SIZE_DEF;
    localparam int CYC_LIMIT = 4000000;

    typedef struct {
        logic [7:0] data;
        logic       last_of_stream;
        bit         drain_first;
    } t_byte_item;

    typedef struct {
        logic [7:0] value;
        logic       index_flag;
        logic       last_flag;
    } t_result_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bwte_in_if  in_if ();
    bwte_out_if out_if ();

    bwt_block_encoder #(.BLOCK_SIZE(NBLK)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if)
    );

    // Drive channel inputs from known values at time zero
    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'h00;
    logic       drv_end   = 1'b0;
    logic       rcv_ready = 1'b0;
    assign in_if.valid      = drv_valid;
    assign in_if.in_byte    = drv_byte;
    assign in_if.stream_end = drv_end;
    assign out_if.ready     = rcv_ready;

    t_byte_item   byte_queue[$];
    t_result_beat bwt_expected[$];
    int           fail_count = 0;
    longint       cycle_count = 0;

    // Predictor state: current block under collection
    logic [7:0] blk_bytes[NBLK];
    int         blk_fill = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compare the rotations starting at a and b over the full length n
    function automatic int rotation_cmp(int a, int b, int n);
        for (int k = 0; k < n; k++) begin
            if (blk_bytes[(a + k) % n] != blk_bytes[(b + k) % n])
                return (blk_bytes[(a + k) % n] < blk_bytes[(b + k) % n]) ? -1 : 1;
        end
        return 0;
    endfunction

    // Absorb one accepted byte; on block close, queue index and last column
    task automatic absorb_byte(logic [7:0] b, logic e);
        int           n;
        int           j;
        int           cur;
        int           order[NBLK];
        int           primary;
        t_result_beat beat;
        if (blk_fill >= NBLK) blk_fill = 0;
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill < NBLK && !e) return;
        n = blk_fill;
        blk_fill = 0;
        for (int i = 0; i < n; i++) begin
            cur = i;
            j = i;
            while (j > 0 && rotation_cmp(order[j - 1], cur, n) > 0) begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = cur;
        end
        primary = 0;
        for (int i = 1; i < n; i++)
            if (rotation_cmp(i, 0, n) < 0) primary++;
        beat.value      = primary[7:0];
        beat.index_flag = 1'b1;
        beat.last_flag  = 1'b0;
        bwt_expected.insert(bwt_expected.size(), beat);
        for (int i = 0; i < n; i++) begin
            beat.value      = blk_bytes[(order[i] + n - 1) % n];
            beat.index_flag = 1'b0;
            beat.last_flag  = (i == n - 1);
            bwt_expected.insert(bwt_expected.size(), beat);
        end
    endtask

    // Queue one block of n bytes in a given content style
    task automatic add_block(int n, int style, bit close_flag, bit drain);
        t_byte_item it;
        logic [7:0] alpha0;
        logic [7:0] alpha1;
        int         period;
        logic [7:0] pat[4];
        alpha0 = 8'($urandom);
        alpha1 = 8'($urandom);
        period = int'($urandom_range(1, 4));
        for (int p = 0; p < 4; p++) pat[p] = 8'($urandom_range(0, 3));
        for (int i = 0; i < n; i++) begin
            case (style)
                0: it.data = 8'($urandom);
                1: it.data = $urandom_range(0, 1) ? alpha1 : alpha0;
                2: it.data = alpha0;
                default: it.data = pat[i % period];
            endcase
            it.last_of_stream = (i == n - 1) ? close_flag : 1'b0;
            it.drain_first    = (i == 0) ? drain : 1'b0;
            byte_queue.insert(byte_queue.size(), it);
        end
    endtask

    // Driver: present bytes, hold until accepted, then idle a random while
    int  send_gap   = 0;
    bit  send_burst = 1'b0;
    always @(posedge i_clk) begin
        logic       nv;
        t_byte_item it;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) absorb_byte(drv_byte, drv_end);
            nv = drv_valid && !in_if.ready;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_queue.size() > 0 &&
                             !(byte_queue[0].drain_first && bwt_expected.size() > 0)) begin
                    it = byte_queue.pop_front();
                    drv_byte <= it.data;
                    drv_end  <= it.last_of_stream;
                    nv = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 11);
                end
            end
            drv_valid <= nv;
        end
    end

    // Monitor: check each result beat, stall the output at random
    int  recv_stall = 0;
    bit  recv_burst = 1'b0;
    always @(posedge i_clk) begin
        t_result_beat exp_beat;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (out_if.valid && rcv_ready) begin
                if (bwt_expected.size() == 0) begin
                    $display("%0t: unexpected beat byte=%0h idx=%0b last=%0b", $time,
                             out_if.out_byte, out_if.is_index, out_if.block_last);
                    fail_count++;
                end else begin
                    exp_beat = bwt_expected.pop_front();
                    if (out_if.out_byte !== exp_beat.value) begin
                        $display("%0t: out_byte expected %0h actual %0h", $time,
                                 exp_beat.value, out_if.out_byte);
                        fail_count++;
                    end
                    if (out_if.is_index !== exp_beat.index_flag) begin
                        $display("%0t: is_index expected %0b actual %0b", $time,
                                 exp_beat.index_flag, out_if.is_index);
                        fail_count++;
                    end
                    if (out_if.block_last !== exp_beat.last_flag) begin
                        $display("%0t: block_last expected %0b actual %0b", $time,
                                 exp_beat.last_flag, out_if.block_last);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 11);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            rcv_ready <= (recv_stall == 0);
        end
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYC_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int total;
        int n;
        // Directed: one-byte block, extremes, repeated rotations, full blocks
        add_block(1, 2, 1'b1, 1'b0);
        add_block(2, 0, 1'b1, 1'b0);
        begin
            t_byte_item it;
            it.drain_first = 1'b0;
            it.data = 8'hFF; it.last_of_stream = 1'b0;
            byte_queue.insert(byte_queue.size(), it);
            it.data = 8'h00; it.last_of_stream = 1'b0;
            byte_queue.insert(byte_queue.size(), it);
            it.data = 8'h00; it.last_of_stream = 1'b0;
            byte_queue.insert(byte_queue.size(), it);
            it.data = 8'hFF; it.last_of_stream = 1'b1;
            byte_queue.insert(byte_queue.size(), it);
        end
        add_block(NBLK, 2, 1'b1, 1'b0);   // full block with stream end: closes once
        add_block(NBLK, 3, 1'b0, 1'b1);   // full block closing on count alone
        add_block(1, 0, 1'b1, 1'b0);
        // Random blocks, mostly short, with varied content
        total = byte_queue.size();
        while (total < 450) begin
            n = ($urandom_range(0, 9) < 2) ? NBLK : $urandom_range(1, NBLK);
            add_block(n, $urandom_range(0, 3),
                      (n == NBLK) ? 1'($urandom_range(0, 1)) : 1'b1,
                      $urandom_range(0, 15) == 0);
            total += n;
        end
        // Close any trailing partial block
        add_block(1, 0, 1'b1, 1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (byte_queue.size() == 0 && !drv_valid);
        wait (bwt_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> bwt_block_encoder.f
sv/bwte_pkg.sv
sv/bwte_if.sv
sv/bwte_mem.sv
sv/bwte_ctrl.sv
sv/bwt_block_encoder.sv
dv/tb_top.sv
